// ===== hdl/wfcs_pkg.sv =====
package wfcs_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int ALPHA_BITS = 16;
   localparam int ALPHA_W    = ALPHA_BITS + 1;
   localparam int LIMIT_W    = 31;
   localparam int CSR_W      = 31;
   localparam int WORK_W     = SAMPLE_W + 2;
   localparam int OPER_W     = 2 * WORK_W;
   localparam int REM_W      = WORK_W + 4;
   localparam int ROOT_ITER  = WORK_W;
   localparam int ITER_W     = $clog2(ROOT_ITER + 1);
   localparam int PROD_W     = OPER_W;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_BITS;

   typedef enum logic [2:0] {
      CSR_ALPHA       = 3'd0,
      CSR_FORCE_NORM  = 3'd1,
      CSR_TORQUE_NORM = 3'd2,
      CSR_FORCE_STEP  = 3'd3,
      CSR_TORQUE_STEP = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic go;
      logic sqrt_mode;
   } rd_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rd_stat_type;

endpackage

// ===== hdl/wfcs_req_if.sv =====
interface wfcs_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [wfcs_pkg::SAMPLE_W-1:0] raw_force_x;
   logic signed [wfcs_pkg::SAMPLE_W-1:0] raw_force_y;
   logic signed [wfcs_pkg::SAMPLE_W-1:0] raw_force_z;
   logic signed [wfcs_pkg::SAMPLE_W-1:0] raw_torque_x;
   logic signed [wfcs_pkg::SAMPLE_W-1:0] raw_torque_y;
   logic signed [wfcs_pkg::SAMPLE_W-1:0] raw_torque_z;

   modport source (output valid, raw_force_x, raw_force_y, raw_force_z,
                   raw_torque_x, raw_torque_y, raw_torque_z, input ready);
   modport sink (input valid, raw_force_x, raw_force_y, raw_force_z,
                 raw_torque_x, raw_torque_y, raw_torque_z, output ready);
endinterface

// ===== hdl/wfcs_rsp_if.sv =====
interface wfcs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [wfcs_pkg::SAMPLE_W-1:0] out_force_x;
   logic signed [wfcs_pkg::SAMPLE_W-1:0] out_force_y;
   logic signed [wfcs_pkg::SAMPLE_W-1:0] out_force_z;
   logic signed [wfcs_pkg::SAMPLE_W-1:0] out_torque_x;
   logic signed [wfcs_pkg::SAMPLE_W-1:0] out_torque_y;
   logic signed [wfcs_pkg::SAMPLE_W-1:0] out_torque_z;

   modport source (output valid, out_force_x, out_force_y, out_force_z,
                   out_torque_x, out_torque_y, out_torque_z, input ready);
   modport sink (input valid, out_force_x, out_force_y, out_force_z,
                 out_torque_x, out_torque_y, out_torque_z, output ready);
endinterface

// ===== hdl/wrench_filter_clamp_slew.sv =====
// Wrench low-pass filter with norm clamp and slew limit.
// req_if carries one six-axis sample (force and torque, signed Q15.16);
// rsp_if returns the new filtered wrench, one response per request.
// Both use valid/ready; a request is taken when valid and ready are high.
// csr_we/csr_index/csr_wdata write the alpha and limit registers; write
// them only while no request is in flight.
// Each vector runs norm clamp, low-pass, step clamp and norm clamp again
// on one shared multiplier and one 34-step root/divide unit. A clamp stage
// that scales the vector runs one root plus three divides; a disabled
// clamp or one whose vector is inside the limit runs neither. Ready is
// high only while the sequencer is idle.
// The response sits in its own register: the next request is taken while
// it waits, and that request's result is held until the old one is taken.
// Reset clears the filter state to zero, alpha to one and all limits to
// zero, and drops any pending response.
module wrench_filter_clamp_slew (
   input  logic                          clock,
   input  logic                          reset,
   wfcs_req_if.sink                      req_if,
   wfcs_rsp_if.source                    rsp_if,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [wfcs_pkg::CSR_W-1:0]    csr_wdata
);
   import wfcs_pkg::*;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_CSTART = 14'b00000000000010,
      ST_CSQ    = 14'b00000000000100,
      ST_CLSQ   = 14'b00000000001000,
      ST_CCMP   = 14'b00000000010000,
      ST_CROOT  = 14'b00000000100000,
      ST_CMUL   = 14'b00000001000000,
      ST_CDGO   = 14'b00000010000000,
      ST_CDIV   = 14'b00000100000000,
      ST_CEND   = 14'b00001000000000,
      ST_FMUL   = 14'b00010000000000,
      ST_FADD   = 14'b00100000000000,
      ST_STORE  = 14'b01000000000000,
      ST_DONE   = 14'b10000000000000
   } state_type;

   localparam int T_W = WORK_W + ALPHA_BITS + 1;

   state_type                state_ff, state_in;
   logic [1:0]               phase_ff, phase_in;
   logic                     vec_ff, vec_in;
   logic [1:0]               cnt_ff, cnt_in;
   logic signed [WORK_W-1:0] w_ff [3];
   logic signed [WORK_W-1:0] w_in [3];
   logic signed [SAMPLE_W-1:0] st_ff [6];
   logic signed [SAMPLE_W-1:0] st_in [6];
   logic signed [SAMPLE_W-1:0] rt_ff [3];
   logic signed [SAMPLE_W-1:0] out_ff [6];
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic [WORK_W-1:0]        n_ff, n_in;
   logic                     neg_ff, neg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     load_out;
   logic [ALPHA_W-1:0]       alpha_ff;
   logic [LIMIT_W-1:0]       lim_ff [4];
   logic [ALPHA_W-1:0]       alpha_sat;
   logic [LIMIT_W-1:0]       lim;
   logic [WORK_W-1:0]        mul_a, mul_b;
   logic [WORK_W-1:0]        w_mag;
   logic signed [SAMPLE_W-1:0] st_sel;
   logic signed [WORK_W:0]   diff;
   logic [WORK_W-1:0]        diff_mag;
   logic signed [T_W-1:0]    t_val;
   logic                     accept;
   rd_cmd_type               rd_cmd;
   rd_stat_type              rd_stat;
   logic [WORK_W-1:0]        rd_res;
   logic [OPER_W-1:0]        rd_oper;

   function automatic logic signed [WORK_W-1:0] sext(input logic signed [SAMPLE_W-1:0] v);
      sext = WORK_W'(v);
   endfunction

   assign accept     = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign alpha_sat  = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign lim        = (phase_ff == 2'd1) ? lim_ff[{1'b1, vec_ff}] : lim_ff[{1'b0, vec_ff}];
   assign w_mag      = w_ff[cnt_ff == 2'd3 ? 2'd0 : cnt_ff][WORK_W-1]
                       ? WORK_W'(-w_ff[cnt_ff == 2'd3 ? 2'd0 : cnt_ff])
                       : WORK_W'(w_ff[cnt_ff == 2'd3 ? 2'd0 : cnt_ff]);
   assign st_sel     = st_ff[vec_ff ? (cnt_ff == 2'd3 ? 3'd3 : 3'(cnt_ff) + 3'd3)
                                    : (cnt_ff == 2'd3 ? 3'd0 : 3'(cnt_ff))];
   assign diff       = (WORK_W+1)'(w_ff[cnt_ff == 2'd3 ? 2'd0 : cnt_ff])
                       - (WORK_W+1)'(st_sel);
   assign diff_mag   = diff[WORK_W] ? WORK_W'(-diff) : WORK_W'(diff);
   assign t_val      = (neg_ff ? -T_W'(prod_ff[T_W-2:0]) : T_W'(prod_ff[T_W-2:0]))
                       + T_W'(ALPHA_ONE >> 1);
   assign rd_oper    = rd_cmd.sqrt_mode ? acc_ff : prod_ff;

   always_comb begin
      mul_a = w_mag;
      mul_b = w_mag;
      case (state_ff)
         ST_CLSQ: begin
            mul_a = WORK_W'(lim);
            mul_b = WORK_W'(lim);
         end
         ST_CMUL: begin
            mul_b = WORK_W'(lim);
         end
         ST_FMUL: begin
            mul_a = diff_mag;
            mul_b = WORK_W'(alpha_sat);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      vec_in       = vec_ff;
      cnt_in       = cnt_ff;
      w_in         = w_ff;
      st_in        = st_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      n_in         = n_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      load_out     = 1'b0;
      rd_cmd.go        = 1'b0;
      rd_cmd.sqrt_mode = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               vec_in   = 1'b0;
               phase_in = 2'd0;
               w_in[0]  = sext(req_if.raw_force_x);
               w_in[1]  = sext(req_if.raw_force_y);
               w_in[2]  = sext(req_if.raw_force_z);
               state_in = ST_CSTART;
            end
         end
         ST_CSTART: begin
            acc_in   = '0;
            cnt_in   = 2'd0;
            state_in = (lim == '0) ? ST_CEND : ST_CSQ;
         end
         ST_CSQ: begin
            prod_in = mul_a * mul_b;
            if (cnt_ff != 2'd0) begin
               acc_in = acc_ff + prod_ff;
            end
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_CLSQ;
            end
         end
         ST_CLSQ: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_CCMP;
         end
         ST_CCMP: begin
            if (acc_ff <= prod_ff) begin
               state_in = ST_CEND;
            end else begin
               rd_cmd.go        = 1'b1;
               rd_cmd.sqrt_mode = 1'b1;
               state_in         = ST_CROOT;
            end
         end
         ST_CROOT: begin
            if (rd_stat.done) begin
               n_in   = rd_res;
               cnt_in = 2'd0;
               state_in = (rd_res == '0) ? ST_CEND : ST_CMUL;
            end
         end
         ST_CMUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_CDGO;
         end
         ST_CDGO: begin
            rd_cmd.go = 1'b1;
            state_in  = ST_CDIV;
         end
         ST_CDIV: begin
            if (rd_stat.done) begin
               w_in[cnt_ff] = w_ff[cnt_ff][WORK_W-1] ? -$signed(rd_res) : $signed(rd_res);
               if (cnt_ff == 2'd2) begin
                  state_in = ST_CEND;
               end else begin
                  cnt_in   = cnt_ff + 2'd1;
                  state_in = ST_CMUL;
               end
            end
         end
         ST_CEND: begin
            cnt_in = 2'd0;
            case (phase_ff)
               2'd0: begin
                  phase_in = 2'd1;
                  state_in = ST_FMUL;
               end
               2'd1: begin
                  phase_in = 2'd2;
                  for (int i = 0; i < 3; i++) begin
                     w_in[i] = w_ff[i] + sext(st_ff[vec_ff ? i + 3 : i]);
                  end
                  state_in = ST_CSTART;
               end
               default: begin
                  state_in = ST_STORE;
               end
            endcase
         end
         ST_FMUL: begin
            prod_in  = mul_a * mul_b;
            neg_in   = diff[WORK_W];
            state_in = ST_FADD;
         end
         ST_FADD: begin
            w_in[cnt_ff] = t_val[ALPHA_BITS +: WORK_W];
            if (cnt_ff == 2'd2) begin
               state_in = ST_CSTART;
            end else begin
               cnt_in   = cnt_ff + 2'd1;
               state_in = ST_FMUL;
            end
         end
         ST_STORE: begin
            for (int i = 0; i < 3; i++) begin
               st_in[vec_ff ? i + 3 : i] = w_ff[i][SAMPLE_W-1:0];
            end
            if (!vec_ff) begin
               vec_in   = 1'b1;
               phase_in = 2'd0;
               for (int i = 0; i < 3; i++) begin
                  w_in[i] = sext(rt_ff[i]);
               end
               state_in = ST_CSTART;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      n_ff    <= n_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      phase_ff <= phase_in;
      vec_ff  <= vec_in;
      if (accept) begin
         rt_ff[0] <= req_if.raw_torque_x;
         rt_ff[1] <= req_if.raw_torque_y;
         rt_ff[2] <= req_if.raw_torque_z;
      end
      if (load_out) begin
         out_ff <= st_ff;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            st_ff[i] <= '0;
         end
         alpha_ff <= ALPHA_ONE;
         for (int i = 0; i < 4; i++) begin
            lim_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         st_ff        <= st_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ALPHA:       alpha_ff  <= csr_wdata[ALPHA_W-1:0];
               CSR_FORCE_NORM:  lim_ff[0] <= csr_wdata[LIMIT_W-1:0];
               CSR_TORQUE_NORM: lim_ff[1] <= csr_wdata[LIMIT_W-1:0];
               CSR_FORCE_STEP:  lim_ff[2] <= csr_wdata[LIMIT_W-1:0];
               CSR_TORQUE_STEP: lim_ff[3] <= csr_wdata[LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   wfcs_root_div u_root_div (
      .clock   (clock),
      .reset   (reset),
      .cmd     (rd_cmd),
      .operand (rd_oper),
      .divisor (n_ff),
      .stat    (rd_stat),
      .result  (rd_res)
   );

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_force_x  = out_ff[0];
   assign rsp_if.out_force_y  = out_ff[1];
   assign rsp_if.out_force_z  = out_ff[2];
   assign rsp_if.out_torque_x = out_ff[3];
   assign rsp_if.out_torque_y = out_ff[4];
   assign rsp_if.out_torque_z = out_ff[5];

   a_go_idle: assert property (@(posedge clock) disable iff (reset)
      rd_cmd.go |-> !rd_stat.busy)
      else $error("root/divide started while busy");

   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      rd_stat.done |-> (state_ff == ST_CROOT || state_ff == ST_CDIV))
      else $error("root/divide result with no waiting state");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_if.ready)
      else $error("request taken without leaving idle");

   a_idle_unit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rd_stat.busy)
      else $error("root/divide busy while idle");

endmodule

// ===== hdl/wfcs_root_div.sv =====
module wfcs_root_div (
   input  logic                         clock,
   input  logic                         reset,
   input  wfcs_pkg::rd_cmd_type         cmd,
   input  logic [wfcs_pkg::OPER_W-1:0]  operand,
   input  logic [wfcs_pkg::WORK_W-1:0]  divisor,
   output wfcs_pkg::rd_stat_type        stat,
   output logic [wfcs_pkg::WORK_W-1:0]  result
);
   import wfcs_pkg::*;

   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [OPER_W-1:0] sh_ff, sh_in;
   logic [WORK_W-1:0] res_ff, res_in;
   logic [WORK_W-1:0] div_ff, div_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              sqrt_ff, sqrt_in;
   logic [REM_W-1:0]  r_shift;
   logic [REM_W-1:0]  trial;

   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      res_in  = res_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sqrt_in = sqrt_ff;
      done_in = 1'b0;
      if (sqrt_ff) begin
         r_shift = {rem_ff[REM_W-3:0], sh_ff[OPER_W-1 -: 2]};
         trial   = REM_W'({res_ff, 2'b01});
      end else begin
         r_shift = {rem_ff[REM_W-2:0], sh_ff[OPER_W-1]};
         trial   = REM_W'(div_ff);
      end
      if (cmd.go) begin
         busy_in = 1'b1;
         sqrt_in = cmd.sqrt_mode;
         cnt_in  = ITER_W'(ROOT_ITER);
         res_in  = '0;
         div_in  = divisor;
         if (cmd.sqrt_mode) begin
            rem_in = '0;
            sh_in  = operand;
         end else begin
            rem_in = REM_W'(operand[OPER_W-1:WORK_W]);
            sh_in  = {operand[WORK_W-1:0], WORK_W'(0)};
         end
      end else if (busy_ff) begin
         if (r_shift >= trial) begin
            rem_in = r_shift - trial;
            res_in = {res_ff[WORK_W-2:0], 1'b1};
         end else begin
            rem_in = r_shift;
            res_in = {res_ff[WORK_W-2:0], 1'b0};
         end
         sh_in  = sqrt_ff ? (sh_ff << 2) : (sh_ff << 1);
         cnt_in = cnt_ff - ITER_W'(1);
         if (cnt_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      res_ff  <= res_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      sqrt_ff <= sqrt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = res_ff;

endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wfcs_pkg::*;

   localparam int DRAIN_CYCLES = 1200;
   localparam int HOLDOFF_CYCLES = 3000;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 140;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] fx;
      logic signed [SAMPLE_W-1:0] fy;
      logic signed [SAMPLE_W-1:0] fz;
      logic signed [SAMPLE_W-1:0] tx;
      logic signed [SAMPLE_W-1:0] ty;
      logic signed [SAMPLE_W-1:0] tz;
   } wrench_t;

   logic clock;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [CSR_W-1:0] csr_wdata;

   wfcs_req_if req_bus();
   wfcs_rsp_if rsp_bus();

   wrench_filter_clamp_slew i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus.sink),
      .rsp_if    (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   wrench_t pending_samples[$];
   wrench_t expected_wrench[$];
   longint filt_state[6];
   longint unsigned alpha_reg;
   longint unsigned norm_lim[2];
   longint unsigned step_lim[2];
   bit failed;
   bit no_idle;
   bit holdoff_req;
   int holdoff_left;
   int stall_cycles;

   function automatic logic [63:0] int_root(logic [127:0] v);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] trial;
      rem = 0;
      root = 0;
      for (int k = 33; k >= 0; k--) begin
         rem = (rem << 2) | 64'(v[2*k +: 2]);
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic logic [127:0] mag(longint v);
      logic [63:0] u;
      u = v < 0 ? -v : v;
      return {64'd0, u};
   endfunction

   function automatic longint scale_comp(longint v, logic [127:0] lim, logic [127:0] n);
      logic [127:0] q;
      q = mag(v) * lim / n;
      return v < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic void clamp_norm(inout longint v0, inout longint v1, inout longint v2,
                                      input longint unsigned lim);
      logic [127:0] sq;
      logic [127:0] lim_w;
      logic [127:0] n;
      if (lim == 0) return;
      lim_w = {64'd0, lim};
      sq = mag(v0) * mag(v0) + mag(v1) * mag(v1) + mag(v2) * mag(v2);
      if (sq <= lim_w * lim_w) return;
      n = {64'd0, int_root(sq)};
      if (n == 0) return;
      v0 = scale_comp(v0, lim_w, n);
      v1 = scale_comp(v1, lim_w, n);
      v2 = scale_comp(v2, lim_w, n);
   endfunction

   function automatic longint lowpass_step(longint x, longint s, longint a);
      longint t;
      t = (x - s) * a + (longint'(1) << (ALPHA_BITS - 1));
      return t >>> ALPHA_BITS;
   endfunction

   function automatic void filter_axis(inout longint s0, inout longint s1, inout longint s2,
                                       input longint r0, input longint r1, input longint r2,
                                       input longint unsigned nl, input longint unsigned sl);
      longint a;
      longint d0, d1, d2;
      a = alpha_reg > (64'd1 << ALPHA_BITS) ? (longint'(1) << ALPHA_BITS) : longint'(alpha_reg);
      clamp_norm(r0, r1, r2, nl);
      d0 = lowpass_step(r0, s0, a);
      d1 = lowpass_step(r1, s1, a);
      d2 = lowpass_step(r2, s2, a);
      clamp_norm(d0, d1, d2, sl);
      r0 = s0 + d0;
      r1 = s1 + d1;
      r2 = s2 + d2;
      clamp_norm(r0, r1, r2, nl);
      s0 = r0;
      s1 = r1;
      s2 = r2;
   endfunction

   function automatic wrench_t filter_sample(wrench_t w);
      wrench_t o;
      filter_axis(filt_state[0], filt_state[1], filt_state[2],
                  longint'(w.fx), longint'(w.fy), longint'(w.fz), norm_lim[0], step_lim[0]);
      filter_axis(filt_state[3], filt_state[4], filt_state[5],
                  longint'(w.tx), longint'(w.ty), longint'(w.tz), norm_lim[1], step_lim[1]);
      o.fx = filt_state[0][SAMPLE_W-1:0];
      o.fy = filt_state[1][SAMPLE_W-1:0];
      o.fz = filt_state[2][SAMPLE_W-1:0];
      o.tx = filt_state[3][SAMPLE_W-1:0];
      o.ty = filt_state[4][SAMPLE_W-1:0];
      o.tz = filt_state[5][SAMPLE_W-1:0];
      return o;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender
   always @(posedge clock) begin
      wrench_t cur;
      wrench_t nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            cur = {req_bus.raw_force_x, req_bus.raw_force_y, req_bus.raw_force_z,
                   req_bus.raw_torque_x, req_bus.raw_torque_y, req_bus.raw_torque_z};
            expected_wrench.push_back(filter_sample(cur));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_samples.size() > 0 && (no_idle || $urandom_range(99) >= 23)) begin
               nxt = pending_samples.pop_front();
               req_bus.raw_force_x <= nxt.fx;
               req_bus.raw_force_y <= nxt.fy;
               req_bus.raw_force_z <= nxt.fz;
               req_bus.raw_torque_x <= nxt.tx;
               req_bus.raw_torque_y <= nxt.ty;
               req_bus.raw_torque_z <= nxt.tz;
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         holdoff_left <= 0;
      end else if (holdoff_req && holdoff_left == 0) begin
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= no_idle || $urandom_range(99) >= 23;
      end
   end

   always @(posedge clock) begin
      wrench_t act;
      wrench_t exp_w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         act = {rsp_bus.out_force_x, rsp_bus.out_force_y, rsp_bus.out_force_z,
                rsp_bus.out_torque_x, rsp_bus.out_torque_y, rsp_bus.out_torque_z};
         if (expected_wrench.size() == 0) begin
            $display("%0t: unexpected response %h", $time, act);
            failed = 1'b1;
         end else begin
            exp_w = expected_wrench.pop_front();
            if (act.fx !== exp_w.fx) begin
               $display("%0t: force_x exp %h act %h", $time, exp_w.fx, act.fx);
               failed = 1'b1;
            end
            if (act.fy !== exp_w.fy) begin
               $display("%0t: force_y exp %h act %h", $time, exp_w.fy, act.fy);
               failed = 1'b1;
            end
            if (act.fz !== exp_w.fz) begin
               $display("%0t: force_z exp %h act %h", $time, exp_w.fz, act.fz);
               failed = 1'b1;
            end
            if (act.tx !== exp_w.tx) begin
               $display("%0t: torque_x exp %h act %h", $time, exp_w.tx, act.tx);
               failed = 1'b1;
            end
            if (act.ty !== exp_w.ty) begin
               $display("%0t: torque_y exp %h act %h", $time, exp_w.ty, act.ty);
               failed = 1'b1;
            end
            if (act.tz !== exp_w.tz) begin
               $display("%0t: torque_z exp %h act %h", $time, exp_w.tz, act.tz);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic wait_drained();
      @(negedge clock);
      while (pending_samples.size() != 0 || req_bus.valid || expected_wrench.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_ALPHA:       alpha_reg = value[ALPHA_W-1:0];
         CSR_FORCE_NORM:  norm_lim[0] = value[LIMIT_W-1:0];
         CSR_TORQUE_NORM: norm_lim[1] = value[LIMIT_W-1:0];
         CSR_FORCE_STEP:  step_lim[0] = value[LIMIT_W-1:0];
         CSR_TORQUE_STEP: step_lim[1] = value[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [CSR_W-1:0] pick_limit();
      case ($urandom_range(7))
         0: return '0;
         1: return CSR_W'(1);
         2: return 31'h7FFF_FFFF;
         3: return CSR_W'($urandom);
         default: return CSR_W'($urandom_range(32'h0030_0000, 1));
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] pick_alpha();
      case ($urandom_range(5))
         0: return '0;
         1: return 31'h1_0000;
         2: return CSR_W'($urandom_range(32'h1_FFFF, 32'h1_0001));
         default: return CSR_W'($urandom_range(32'h1_0000, 1));
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_comp();
      logic signed [SAMPLE_W-1:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom;
         4, 5, 6: v = $urandom_range(32'h0014_0000, 0);
         7: v = $urandom_range(200, 0);
         8: v = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: v = 0;
      endcase
      if (v != 32'sh8000_0000 && $urandom_range(1)) v = -v;
      return v;
   endfunction

   function automatic wrench_t pick_sample();
      wrench_t w;
      w = {pick_comp(), pick_comp(), pick_comp(), pick_comp(), pick_comp(), pick_comp()};
      if ($urandom_range(19) == 0) begin
         w.fx = 0;
         w.fy = 0;
         w.fz = 0;
      end
      if ($urandom_range(19) == 0) begin
         w.tx = 0;
         w.ty = 0;
         w.tz = 0;
      end
      return w;
   endfunction

   task automatic push_sample(logic signed [SAMPLE_W-1:0] f, logic signed [SAMPLE_W-1:0] t);
      pending_samples.push_back({f, -f, f, t, t, -t});
   endtask

   initial begin
      csr_we = 1'b0;
      csr_index = CSR_ALPHA;
      csr_wdata = 0;
      no_idle = 1'b0;
      holdoff_req = 1'b0;
      for (int i = 0; i < 6; i++) filt_state[i] = 0;
      alpha_reg = 64'd1 << ALPHA_BITS;
      norm_lim[0] = 0;
      norm_lim[1] = 0;
      step_lim[0] = 0;
      step_lim[1] = 0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // pass-through after reset
      push_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
      push_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
      push_sample(0, -1);
      push_sample(1, 0);
      wait_drained();

      // alpha zero holds state, alpha above one saturates, tiny alpha rounds
      write_reg(CSR_ALPHA, 0);
      end_writes();
      push_sample(32'sh1234_5678, -32'sh0765_4321);
      wait_drained();
      write_reg(CSR_ALPHA, 31'h1_FFFF);
      end_writes();
      push_sample(-32'sh0001_8000, 32'sh0003_0000);
      push_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
      wait_drained();
      write_reg(CSR_ALPHA, 1);
      end_writes();
      push_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
      push_sample(-3, 3);
      wait_drained();

      // clamp extremes, zero vector under an active limit
      write_reg(CSR_ALPHA, 31'h1_0000);
      write_reg(CSR_FORCE_NORM, 1);
      write_reg(CSR_TORQUE_NORM, 31'h7FFF_FFFF);
      write_reg(CSR_FORCE_STEP, 31'h7FFF_FFFF);
      write_reg(CSR_TORQUE_STEP, 1);
      end_writes();
      push_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
      push_sample(0, 0);
      push_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
      push_sample(32'sh0002_0000, -32'sh0005_0000);
      wait_drained();
      write_reg(CSR_ALPHA, 31'h0000_8000);
      write_reg(CSR_FORCE_NORM, 31'h0004_0000);
      write_reg(CSR_TORQUE_NORM, 31'h0002_0000);
      write_reg(CSR_FORCE_STEP, 31'h0000_4000);
      write_reg(CSR_TORQUE_STEP, 0);
      end_writes();
      push_sample(32'sh0010_0000, -32'sh0010_0000);
      push_sample(-32'sh0010_0000, 32'sh0000_8000);
      push_sample(0, 0);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         write_reg(CSR_ALPHA, pick_alpha());
         write_reg(CSR_FORCE_NORM, pick_limit());
         write_reg(CSR_TORQUE_NORM, pick_limit());
         write_reg(CSR_FORCE_STEP, pick_limit());
         write_reg(CSR_TORQUE_STEP, pick_limit());
         end_writes();
         no_idle = (p == 2);
         for (int i = 0; i < PHASE_ITEMS; i++) pending_samples.push_back(pick_sample());
         if (p == 4) begin
            @(negedge clock);
            holdoff_req = 1'b1;
            @(negedge clock);
            @(negedge clock);
            holdoff_req = 1'b0;
         end
         wait_drained();
      end
      no_idle = 1'b0;

      if (!failed) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
